FILE: design/u8u16_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// shared types and constants of the lenient utf-8 to utf-16 transcoder
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [15:0] REPL_CHAR = 16'hFFFD;
    localparam logic [5:0]  HI_SURR   = 6'b110110;
    localparam logic [5:0]  LO_SURR   = 6'b110111;
    localparam logic [20:0] PLANE1    = 21'h010000;
    localparam logic [20:0] MAX_POINT = 21'h10FFFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_UNIT,
        KIND_PAIR
    } t_kind;

    // repl: replacement units first, then the tail unit or surrogate pair
    typedef struct packed {
        logic [1:0]  repl;
        t_kind       kind;
        logic [19:0] data;
    } t_desc;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_stat;

endpackage
`default_nettype wire

FILE: design/u8u16_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_front
// decodes one byte per transaction into a descriptor of the units it causes
// ----------------------------------------------------------------------------
module u8u16_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_in_byte,
    input  wire logic                i_end_of_text,
    output u8u16_pkg::t_desc         o_desc,
    output logic                     o_wr
);

    logic [1:0]  r_exp;
    logic [1:0]  r_taken;
    logic [20:0] r_partial;
    logic [1:0]  n_exp;
    logic [1:0]  n_taken;
    logic [20:0] n_partial;

    logic [20:0] cont_point;
    logic [20:0] plane_off;
    logic [1:0]  taken_inc;
    logic        do_fresh;
    u8u16_pkg::t_desc desc;

    assign cont_point = {r_partial[14:0], i_in_byte[5:0]};
    assign plane_off  = cont_point - u8u16_pkg::PLANE1;
    assign taken_inc  = r_taken + 2'd1;

    always_comb begin
        n_exp     = r_exp;
        n_taken   = r_taken;
        n_partial = r_partial;
        desc      = '{repl: 2'd0, kind: u8u16_pkg::KIND_NONE, data: 20'd0};
        do_fresh  = 1'b0;
        if (i_accept) begin
            if (r_exp != 2'd0) begin
                if (i_in_byte[7:6] == 2'b10) begin
                    if (taken_inc >= r_exp) begin
                        n_exp     = 2'd0;
                        n_taken   = 2'd0;
                        n_partial = 21'd0;
                        if (cont_point >= u8u16_pkg::PLANE1 &&
                            cont_point <= u8u16_pkg::MAX_POINT) begin
                            desc.kind = u8u16_pkg::KIND_PAIR;
                            desc.data = plane_off[19:0];
                        end else begin
                            desc.kind = u8u16_pkg::KIND_UNIT;
                            desc.data = {4'd0, cont_point[15:0]};
                        end
                    end else if (i_end_of_text) begin
                        desc.repl = taken_inc + 2'd1;
                        n_exp     = 2'd0;
                        n_taken   = 2'd0;
                        n_partial = 21'd0;
                    end else begin
                        n_taken   = taken_inc;
                        n_partial = cont_point;
                    end
                end else begin
                    // broken sequence
                    desc.repl = r_taken + 2'd1;
                    n_exp     = 2'd0;
                    n_taken   = 2'd0;
                    n_partial = 21'd0;
                    do_fresh  = 1'b1;
                end
            end else begin
                do_fresh = 1'b1;
            end

            if (do_fresh) begin
                if (i_in_byte[7] == 1'b0) begin
                    desc.kind = u8u16_pkg::KIND_UNIT;
                    desc.data = {12'd0, i_in_byte};
                end else if (i_in_byte[7:6] == 2'b10 || i_in_byte[7:3] == 5'b11111
                             || i_end_of_text) begin
                    desc.kind = u8u16_pkg::KIND_UNIT;
                    desc.data = {4'd0, u8u16_pkg::REPL_CHAR};
                end else if (i_in_byte[7:5] == 3'b110) begin
                    n_exp     = 2'd1;
                    n_taken   = 2'd0;
                    n_partial = {16'd0, i_in_byte[4:0]};
                end else if (i_in_byte[7:4] == 4'b1110) begin
                    n_exp     = 2'd2;
                    n_taken   = 2'd0;
                    n_partial = {17'd0, i_in_byte[3:0]};
                end else begin
                    n_exp     = 2'd3;
                    n_taken   = 2'd0;
                    n_partial = {18'd0, i_in_byte[2:0]};
                end
            end
        end
    end

    assign o_desc = desc;
    assign o_wr   = i_accept && (desc.repl != 2'd0 || desc.kind != u8u16_pkg::KIND_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp     <= 2'd0;
            r_taken   <= 2'd0;
            r_partial <= 21'd0;
        end else begin
            r_exp     <= n_exp;
            r_taken   <= n_taken;
            r_partial <= n_partial;
        end
    end

endmodule
`default_nettype wire

FILE: design/u8u16_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_fifo
// short descriptor queue between decoder and unit emitter
// ----------------------------------------------------------------------------
module u8u16_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr,
    input  wire u8u16_pkg::t_desc    i_wdata,
    input  wire logic                i_rd,
    output u8u16_pkg::t_desc         o_rdata,
    output u8u16_pkg::t_fifo_stat    o_stat
);

    u8u16_pkg::t_desc r_mem [u8u16_pkg::FIFO_DEPTH];

    logic [u8u16_pkg::FIFO_PTR_W-1:0] r_wptr;
    logic [u8u16_pkg::FIFO_PTR_W-1:0] r_rptr;
    logic [u8u16_pkg::FIFO_CNT_W-1:0] r_count;
    logic                             wr_en;
    logic                             rd_en;

    localparam logic [u8u16_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        u8u16_pkg::FIFO_PTR_W'(u8u16_pkg::FIFO_DEPTH - 1);
    localparam logic [u8u16_pkg::FIFO_CNT_W-1:0] FULL_CNT =
        u8u16_pkg::FIFO_CNT_W'(u8u16_pkg::FIFO_DEPTH);

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;
    assign wr_en        = i_wr && !o_stat.full;
    assign rd_en        = i_rd && !o_stat.empty;
    assign o_rdata      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/u8u16_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_back
// expands descriptors into utf-16 code units, one unit per cycle while pop is high
// ----------------------------------------------------------------------------
module u8u16_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire u8u16_pkg::t_desc    i_desc,
    input  wire logic                i_desc_empty,
    output logic                     o_desc_rd,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output logic [15:0]              o_code_unit,
    output logic                     o_run_last
);

    logic             r_cur_valid;
    u8u16_pkg::t_desc r_cur;
    logic             r_hi_done;
    logic             r_out_valid;
    logic [15:0]      r_out_unit;
    logic             r_out_last;

    logic [15:0] emit_unit;
    logic        emit_last;
    logic        adv;
    logic        load;

    always_comb begin
        emit_unit = u8u16_pkg::REPL_CHAR;
        emit_last = 1'b0;
        if (r_cur.repl != 2'd0) begin
            emit_last = (r_cur.repl == 2'd1) && (r_cur.kind == u8u16_pkg::KIND_NONE);
        end else begin
            case (r_cur.kind)
                u8u16_pkg::KIND_UNIT: begin
                    emit_unit = r_cur.data[15:0];
                    emit_last = 1'b1;
                end
                u8u16_pkg::KIND_PAIR: begin
                    if (r_hi_done) begin
                        emit_unit = {u8u16_pkg::LO_SURR, r_cur.data[9:0]};
                        emit_last = 1'b1;
                    end else begin
                        emit_unit = {u8u16_pkg::HI_SURR, r_cur.data[19:10]};
                    end
                end
                default: begin
                    emit_last = 1'b1;
                end
            endcase
        end
    end

    assign adv       = r_cur_valid && (!r_out_valid || i_pop);
    assign load      = !i_desc_empty && (!r_cur_valid || (adv && emit_last));
    assign o_desc_rd = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_desc;
        end else if (adv && r_cur.repl != 2'd0) begin
            r_cur.repl <= r_cur.repl - 2'd1;
        end
        if (adv) begin
            r_out_unit <= emit_unit;
            r_out_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_hi_done   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_cur_valid <= 1'b1;
                r_hi_done   <= 1'b0;
            end else if (adv && emit_last) begin
                r_cur_valid <= 1'b0;
            end else if (adv && r_cur.repl == 2'd0 && r_cur.kind == u8u16_pkg::KIND_PAIR) begin
                r_hi_done <= 1'b1;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_code_unit = r_out_unit;
    assign o_run_last  = r_out_last;

endmodule
`default_nettype wire

FILE: design/utf8_to_utf16_lenient.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_lenient
// lenient utf-8 to utf-16 transcoder with queue-style channels
// ----------------------------------------------------------------------------
// input channel: present one byte on i_in_byte with i_end_of_text; the
// transaction happens when push is high and full is low. a byte is taken
// every cycle as long as the descriptor queue (4 entries) has room.
// output channel: while empty is low, o_code_unit and o_run_last hold the
// oldest code unit; pop high takes it. o_run_last marks the last unit
// caused by one input byte. a byte that only opens or extends a sequence
// gives no unit.
// path: a byte's units pass the descriptor queue, the current-descriptor
// register and the output register. the emitter sends one unit per cycle
// while pop is high; a byte causes at most four units, and a byte that
// gives no unit writes no descriptor. one byte per cycle is sustained when
// pop is high and the average is at most one unit per byte; surrogate pairs
// and replacement runs are absorbed by the queue.
// reset (synchronous, active low) clears the pending sequence, the queue
// and the output register. when pop is held low the output holds, the queue
// fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module utf8_to_utf16_lenient (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_text,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_code_unit,
    output logic             o_run_last
);

    u8u16_pkg::t_desc       wr_desc;
    u8u16_pkg::t_desc       rd_desc;
    u8u16_pkg::t_fifo_stat  fifo_stat;
    logic                   wr;
    logic                   rd;
    logic                   accept;

    assign full   = fifo_stat.full;
    assign accept = push && !fifo_stat.full;

    u8u16_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_desc        (wr_desc),
        .o_wr          (wr)
    );

    u8u16_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_wdata (wr_desc),
        .i_rd    (rd),
        .o_rdata (rd_desc),
        .o_stat  (fifo_stat)
    );

    u8u16_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (rd_desc),
        .i_desc_empty (fifo_stat.empty),
        .o_desc_rd    (rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_code_unit  (o_code_unit),
        .o_run_last   (o_run_last)
    );

    a_desc_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr |-> (wr_desc.repl != 2'd0 || wr_desc.kind != u8u16_pkg::KIND_NONE))
        else $error("descriptor written with no units");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.count <= u8u16_pkg::FIFO_CNT_W'(u8u16_pkg::FIFO_DEPTH))
        else $error("queue count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> fifo_stat.count == $past(fifo_stat.count) + 1'b1)
        else $error("queue count did not follow a write");

endmodule
`default_nettype wire
